// ===== rtl/keyboard_scancode_to_ascii_macros.svh =====
// Assertion macros for the keyboard scan code decoder.
// Used by the top level only; depends on nothing else.
`ifndef KEYBOARD_SCANCODE_TO_ASCII_MACROS_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_MACROS_SVH

`ifndef SYNTHESIS
// Checks that a condition implies a consequence in the same cycle.
`define KSA_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define KSA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define KSA_ASSERT_SAME(label, clk, rst_n, cond, cons, msg)
`define KSA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg)
`endif

`endif

// ===== rtl/kbd_s2a_pkg.sv =====
// Package for the keyboard scan code decoder: codes, shared structs and
// the scan code set 2 character table. Depends on nothing.
`default_nettype none

package kbd_s2a_pkg;

    localparam logic [7:0] BREAK_CODE  = 8'hF0;
    localparam logic [7:0] LSHIFT_CODE = 8'h12;
    localparam logic [7:0] RSHIFT_CODE = 8'h59;

    // One decoded result from the decode stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] character;
    } result_t;

    // Keyboard modifier state as seen by the top level.
    typedef struct packed {
        logic shift_active;
        logic break_pending;
    } flags_t;

    // Character lookup for codes below 0x80; unmapped entries give zero.
    function automatic logic [7:0] char_lookup(input logic [6:0] idx, input logic shift);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            7'h01: ch = 8'hF8;
            7'h03: ch = 8'hF4;
            7'h04: ch = 8'hF2;
            7'h05: ch = 8'hF0;
            7'h06: ch = 8'hF1;
            7'h07: ch = 8'hFB;
            7'h09: ch = 8'hF9;
            7'h0A: ch = 8'hF7;
            7'h0B: ch = 8'hF5;
            7'h0C: ch = 8'hF3;
            7'h0D: ch = 8'h09;
            7'h0E: ch = shift ? 8'h7E : 8'h60;
            7'h12: ch = 8'h12;
            7'h14: ch = 8'h82;
            7'h15: ch = shift ? "Q" : "q";
            7'h16: ch = shift ? "!" : "1";
            7'h1A: ch = shift ? "Z" : "z";
            7'h1B: ch = shift ? "S" : "s";
            7'h1C: ch = shift ? "A" : "a";
            7'h1D: ch = shift ? "W" : "w";
            7'h1E: ch = shift ? "@" : "2";
            7'h21: ch = shift ? "C" : "c";
            7'h22: ch = shift ? "X" : "x";
            7'h23: ch = shift ? "D" : "d";
            7'h24: ch = shift ? "E" : "e";
            7'h25: ch = shift ? "$" : "4";
            7'h26: ch = shift ? "#" : "3";
            7'h29: ch = " ";
            7'h2A: ch = shift ? "V" : "v";
            7'h2B: ch = shift ? "F" : "f";
            7'h2C: ch = shift ? "T" : "t";
            7'h2D: ch = shift ? "R" : "r";
            7'h2E: ch = shift ? "%" : "5";
            7'h31: ch = shift ? "N" : "n";
            7'h32: ch = shift ? "B" : "b";
            7'h33: ch = shift ? "H" : "h";
            7'h34: ch = shift ? "G" : "g";
            7'h35: ch = shift ? "Y" : "y";
            7'h36: ch = shift ? "^" : "6";
            7'h3A: ch = shift ? "M" : "m";
            7'h3B: ch = shift ? "J" : "j";
            7'h3C: ch = shift ? "U" : "u";
            7'h3D: ch = shift ? "&" : "7";
            7'h3E: ch = shift ? "*" : "8";
            7'h41: ch = shift ? "<" : ",";
            7'h42: ch = shift ? "K" : "k";
            7'h43: ch = shift ? "I" : "i";
            7'h44: ch = shift ? "O" : "o";
            7'h45: ch = shift ? ")" : "0";
            7'h46: ch = shift ? "(" : "9";
            7'h49: ch = shift ? ">" : ".";
            7'h4A: ch = shift ? "?" : "/";
            7'h4B: ch = shift ? "L" : "l";
            7'h4C: ch = shift ? ":" : ";";
            7'h4D: ch = shift ? "P" : "p";
            7'h4E: ch = shift ? "_" : "-";
            7'h52: ch = shift ? 8'h22 : 8'h27;
            7'h54: ch = shift ? "{" : "[";
            7'h55: ch = shift ? "+" : "=";
            7'h58: ch = 8'h80;
            7'h59: ch = 8'h59;
            7'h5A: ch = 8'h0D;
            7'h5B: ch = shift ? "}" : "]";
            7'h5D: ch = shift ? 8'h7C : 8'h5C;
            7'h66: ch = 8'h08;
            7'h69: ch = "1";
            7'h6B: ch = "4";
            7'h6C: ch = "7";
            7'h71: ch = ".";
            7'h72: ch = "2";
            7'h73: ch = "5";
            7'h74: ch = "6";
            7'h75: ch = "8";
            7'h76: ch = 8'h1B;
            7'h77: ch = 8'h81;
            7'h78: ch = 8'hFA;
            7'h79: ch = "+";
            7'h7A: ch = "3";
            7'h7B: ch = "-";
            7'h7C: ch = "*";
            7'h7D: ch = "9";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kbd_s2a_decode.sv =====
// Decode stage: holds the shift and break flags and turns one registered
// scan code into zero or one character. Depends on kbd_s2a_pkg.
`default_nettype none

module kbd_s2a_decode (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     advance,
    input  wire  [7:0]              scan_code,
    output kbd_s2a_pkg::result_t    result,
    output kbd_s2a_pkg::flags_t     flags
);

    logic shift_reg;
    logic shift_next;
    logic brk_reg;
    logic brk_next;
    logic is_shift;

    assign is_shift = (scan_code == kbd_s2a_pkg::LSHIFT_CODE) ||
                      (scan_code == kbd_s2a_pkg::RSHIFT_CODE);

    // Next flag state and the result for the current code.
    always_comb
    begin
        shift_next       = shift_reg;
        brk_next         = brk_reg;
        result.valid     = 1'b0;
        result.character = kbd_s2a_pkg::char_lookup(scan_code[6:0], shift_reg);
        if (brk_reg)
        begin
            // The byte after a break prefix ends the break and gives no character; a shift code also releases shift.
            brk_next = 1'b0;
            if (is_shift)
            begin
                shift_next = 1'b0;
            end
        end
        else if (scan_code == kbd_s2a_pkg::BREAK_CODE)
        begin
            brk_next = 1'b1;
        end
        else if (is_shift)
        begin
            shift_next = 1'b1;
        end
        else if (!scan_code[7])
        begin
            result.valid = 1'b1;
        end
    end

    // Flags change only when the stage hands its code on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            brk_reg   <= 1'b0;
        end
        else if (advance)
        begin
            shift_reg <= shift_next;
            brk_reg   <= brk_next;
        end
    end

    assign flags.shift_active  = shift_reg;
    assign flags.break_pending = brk_reg;

endmodule

`default_nettype wire

// ===== rtl/keyboard_scancode_to_ascii.sv =====
// Keyboard scan code set 2 to ASCII decoder, top level.
// Path: a character reaches the output register after its scan code has passed the input register.
// Throughput: one scan code per cycle unless the output stalls; the input register feeds the
// decode logic and the table lookup, whose result lands in the output register.
// Reset: asynchronous, active low; clears both pipeline stages, shift and break flags.
// Depends on kbd_s2a_pkg, kbd_s2a_decode and keyboard_scancode_to_ascii_macros.svh.
`default_nettype none

`include "keyboard_scancode_to_ascii_macros.svh"

module keyboard_scancode_to_ascii (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] scan_code
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] character
);

    logic                  in_valid_reg;
    logic [7:0]            in_code_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_char_reg;
    logic                  out_free;
    logic                  advance;
    kbd_s2a_pkg::result_t  dec_result;
    kbd_s2a_pkg::flags_t   dec_flags;

    // The output slot is free when empty or when its transaction completes now.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_code_reg <= s_axis_tdata;
        end
    end

    kbd_s2a_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .scan_code (in_code_reg),
        .result    (dec_result),
        .flags     (dec_flags)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && dec_result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec_result.valid)
        begin
            out_char_reg <= dec_result.character;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;

    // Checks on the pipeline and flag logic.
    `KSA_ASSERT_SAME(a_ready_stall, clk, rst_n, !s_axis_tready, in_valid_reg && m_axis_tvalid && !m_axis_tready, "input stalled without a blocked output")
    `KSA_ASSERT_NEXT(a_break_arms, clk, rst_n, advance && !dec_flags.break_pending && in_code_reg == kbd_s2a_pkg::BREAK_CODE, dec_flags.break_pending, "break prefix did not arm the break flag")
    `KSA_ASSERT_NEXT(a_break_silent, clk, rst_n, advance && dec_flags.break_pending, !m_axis_tvalid && !dec_flags.break_pending, "byte after break gave a character or kept the break")

endmodule

`default_nettype wire
